@@ src/fhec_pkg.sv @@
package fhec_pkg;

  localparam logic [7:0]  CRC8_POLY  = 8'h1b;
  localparam logic [31:0] CRC32_POLY = 32'h04c11db7;
  localparam int          QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_CRC8   = 2'd0;
  localparam logic [1:0] KIND_SUM    = 2'd1;
  localparam logic [1:0] KIND_PARITY = 2'd2;
  localparam logic [1:0] KIND_CRC32  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  check_kind;
    logic [31:0] check_value;
    logic        parity_ok;
    logic [4:0]  frame_length;
    logic [1:0]  source_group;
    logic [5:0]  source_station;
    logic [1:0]  dest_group;
    logic [5:0]  dest_station;
    logic [1:0]  language_code;
    logic        fragmented;
    logic [1:0]  sequence_number;
  } out_item_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       clear;
    logic [4:0] idx;
    logic       last;
  } work_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] r, logic [7:0] b);
    logic [7:0] x;
    logic       top;
    x = r;
    for (int k = 0; k < 8; k++) begin
      top = x[7];
      x = {x[6:0], b[7-k]};
      if (top) x = x ^ CRC8_POLY;
    end
    return x;
  endfunction

  function automatic logic [31:0] crc32_byte(logic [31:0] r, logic [7:0] b);
    logic [31:0] x;
    logic        top;
    x = r;
    for (int k = 0; k < 8; k++) begin
      top = x[31];
      x = {x[30:0], b[7-k]};
      if (top) x = x ^ CRC32_POLY;
    end
    return x;
  endfunction

endpackage

@@ src/fhec_front.sv @@
module fhec_front (
  input  logic               clk,
  input  logic               rst,
  input  fhec_pkg::in_item_t in_item,
  input  logic               accept,
  output fhec_pkg::work_t    work,
  output logic               work_valid
);

  logic [4:0] byte_count;
  logic       in_frame;
  logic [7:0] control_byte;
  logic [7:0] info_byte;
  logic [4:0] idx;
  logic [4:0] count_next;
  logic [1:0] kind;
  logic [7:0] info_now;
  logic [4:0] len;
  logic       live;

  assign idx        = in_item.start_of_frame ? 5'd0 : byte_count;
  assign live       = in_item.start_of_frame | in_frame;
  assign count_next = idx + 5'd1;
  assign kind       = (idx == 5'd1) ? in_item.data_byte[3:2] : control_byte[3:2];
  assign info_now   = (idx == 5'd4) ? in_item.data_byte : info_byte;
  assign len = 5'd5 + 5'({2'b0, info_now[5:3]} * 5'd3)
             + ((kind == fhec_pkg::KIND_CRC32) ? 5'd4 : 5'd1);

  assign work_valid     = accept & live;
  assign work.data_byte = in_item.data_byte;
  assign work.clear     = in_item.start_of_frame;
  assign work.idx       = idx;
  assign work.last      = (idx >= 5'd4) && (count_next == len);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      in_frame     <= 1'b0;
      control_byte <= '0;
      info_byte    <= '0;
    end else if (accept && live) begin
      byte_count <= count_next;
      in_frame   <= !work.last;
      if (idx == 5'd1) control_byte <= in_item.data_byte;
      if (idx == 5'd4) info_byte <= in_item.data_byte;
    end
  end

endmodule

@@ src/fhec_queue.sv @@
module fhec_queue #(
  parameter int DEPTH = fhec_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  fhec_pkg::work_t wr_data,
  output logic            full,
  input  logic            rd,
  output fhec_pkg::work_t rd_data,
  output logic            empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fhec_pkg::work_t mem [DEPTH];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [AW:0]     cnt;

  assign full    = (cnt == (AW+1)'(DEPTH));
  assign empty   = (cnt == '0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (rd && !empty) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule

@@ src/fhec_back.sv @@
module fhec_back (
  input  logic                clk,
  input  logic                rst,
  input  fhec_pkg::work_t     work,
  input  logic                work_valid,
  output logic                work_take,
  output fhec_pkg::out_item_t result,
  output logic                empty,
  input  logic                pop
);

  logic [7:0]  control_byte, origin_byte, destination_byte, info_byte;
  logic [7:0]  crc8_r, crc8_next;
  logic [31:0] crc32_r, crc32_next;
  logic        par, par_next;
  logic [19:0] sum, sum_next;
  logic [7:0]  high, high_next;
  logic [7:0]  ctl_now, org_now, dst_now, inf_now;
  logic [1:0]  kind;
  logic        out_valid;
  logic        out_free;

  assign out_free  = !out_valid || pop;
  assign work_take = work_valid && out_free;
  assign empty     = !out_valid;

  always_comb begin
    logic [7:0]  c8;
    logic [31:0] c32;
    logic        p;
    logic [19:0] s;
    logic [7:0]  h;
    c8  = work.clear ? '0 : crc8_r;
    c32 = work.clear ? '0 : crc32_r;
    p   = work.clear ? 1'b0 : par;
    s   = work.clear ? '0 : sum;
    h   = work.clear ? '0 : high;
    crc8_next  = fhec_pkg::crc8_byte(c8, work.data_byte);
    crc32_next = fhec_pkg::crc32_byte(c32, work.data_byte);
    par_next   = p ^ (^work.data_byte);
    if (!work.idx[0]) begin
      high_next = work.data_byte;
      sum_next  = s;
      if (work.last) sum_next = s + 20'({work.data_byte, 8'h00});
    end else begin
      high_next = '0;
      sum_next  = s + 20'({h, work.data_byte});
    end
  end

  assign ctl_now = (work.idx == 5'd1) ? work.data_byte : control_byte;
  assign org_now = (work.idx == 5'd2) ? work.data_byte : origin_byte;
  assign dst_now = (work.idx == 5'd3) ? work.data_byte : destination_byte;
  assign inf_now = (work.idx == 5'd4) ? work.data_byte : info_byte;
  assign kind    = ctl_now[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      control_byte     <= '0;
      origin_byte      <= '0;
      destination_byte <= '0;
      info_byte        <= '0;
      crc8_r           <= '0;
      crc32_r          <= '0;
      par              <= 1'b0;
      sum              <= '0;
      high             <= '0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      if (work_take) begin
        control_byte     <= ctl_now;
        origin_byte      <= org_now;
        destination_byte <= dst_now;
        info_byte        <= inf_now;
        crc8_r           <= crc8_next;
        crc32_r          <= crc32_next;
        par              <= par_next;
        sum              <= sum_next;
        high             <= work.last ? '0 : high_next;
        if (work.last) begin
          out_valid <= 1'b1;
          result.check_kind <= kind;
          case (kind)
            fhec_pkg::KIND_CRC8:   result.check_value <= {24'd0, crc8_next};
            fhec_pkg::KIND_SUM:    result.check_value <= {12'd0, sum_next};
            fhec_pkg::KIND_PARITY: result.check_value <= '0;
            default:               result.check_value <= crc32_next;
          endcase
          result.parity_ok <= (kind == fhec_pkg::KIND_PARITY)
                              ? (ctl_now[0] ? par_next : !par_next) : 1'b0;
          result.frame_length    <= work.idx + 5'd1;
          result.source_group    <= org_now[7:6];
          result.source_station  <= org_now[5:0];
          result.dest_group      <= dst_now[7:6];
          result.dest_station    <= dst_now[5:0];
          result.language_code   <= inf_now[7:6];
          result.fragmented      <= inf_now[2];
          result.sequence_number <= inf_now[1:0];
        end
      end
    end
  end

endmodule

@@ src/frame_header_error_check_top.sv @@
// a frame's result goes via the byte queue and the back end's result register to the ports
// throughput: one byte per cycle unless full; crc steps unrolled per byte in the back end
// full rises only when the 4-entry byte queue fills while results wait to be popped
// reset: synchronous active-high rst clears frame state, checks and queue, no clearing pass
module frame_header_error_check_top #(
  parameter int QUEUE_DEPTH = fhec_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  fhec_pkg::in_item_t  in_item,
  input  logic                push,
  output logic                full,
  output fhec_pkg::out_item_t out_item,
  output logic                empty,
  input  logic                pop
);

  fhec_pkg::work_t f_work, b_work;
  logic            f_valid;
  logic            q_empty;
  logic            b_take;

  // front: tracks framing and flags the last byte of each frame
  fhec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_item    (in_item),
    .accept     (push && !full),
    .work       (f_work),
    .work_valid (f_valid)
  );

  // queue decouples classification from check arithmetic
  fhec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_valid),
    .wr_data (f_work),
    .full    (full),
    .rd      (b_take),
    .rd_data (b_work),
    .empty   (q_empty)
  );

  // back: runs crc8, crc32, parity and word sum, holds the result register
  fhec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work       (b_work),
    .work_valid (!q_empty),
    .work_take  (b_take),
    .result     (out_item),
    .empty      (empty),
    .pop        (pop)
  );

endmodule
